[src/iss_pkg.sv]
// Shared widths, operation codes and status codes of the indexed sequence store.
package iss_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int OP_W         = 3;
	localparam int POS_W        = 4;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 2;
	localparam int COUNT_OUT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_REAR  = 3'd1,
		OP_DEL_FRONT = 3'd2,
		OP_DEL_REAR  = 3'd3,
		OP_INS_AT    = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_READ      = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE = 2'd0,
		ST_NOOP = 2'd1,
		ST_FULL = 2'd2
	} status_t;

endpackage

[src/indexed_sequence_store_core.sv]
// Top level: ordered store of signed words with positional insert, delete and read.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  req     | req_valid, req_stall | op, position, item_value
//  rsp     | rsp_valid, rsp_stall | status, read_value, entry_count
//
// One request per cycle while the response is not stalled; a request goes from the request
// register through one pass of shift/compare logic per cell into the response register.
// Every cell shifts, loads the new item or holds in parallel, set by comparing its index with the target.
// Reset clears the element count and both valid flags; cell contents are not reset.
// A stalled response holds; the request register then holds and req_stall rises.

module indexed_sequence_store_core #(
	parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [iss_pkg::OP_W-1:0]            op,
	input  logic [iss_pkg::POS_W-1:0]           position,
	input  logic signed [iss_pkg::DATA_W-1:0]   item_value,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [iss_pkg::STATUS_W-1:0]        status,
	output logic signed [iss_pkg::DATA_W-1:0]   read_value,
	output logic [iss_pkg::COUNT_OUT_W-1:0]     entry_count
);
	import iss_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int EW   = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
	localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
	localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

	// request register
	logic               valid_s1;
	op_t                op_s1;
	logic [POS_W-1:0]   pos_s1;
	logic [DATA_W-1:0]  val_s1;

	// store state
	logic [DATA_W-1:0]  cells_q [CAPACITY];
	logic [DATA_W-1:0]  cells_nx [CAPACITY];
	logic [CW-1:0]      count_q;

	// response register
	logic                    rsp_valid_q;
	status_t                 status_q;
	logic [DATA_W-1:0]       read_value_q;
	logic [COUNT_OUT_W-1:0]  entry_count_q;

	logic               rsp_free;
	logic               fire;
	logic               req_take;
	logic [EW-1:0]      count_e;
	logic [EW-1:0]      pos_e;
	logic [EW-1:0]      idx;
	logic [EW-1:0]      cnt_nx_e;
	logic [CW-1:0]      cnt_nx;
	logic               full;
	logic               empty;
	logic               pos_ok;
	logic               do_ins;
	logic               do_del;
	status_t            st_nx;
	logic [DATA_W-1:0]  rd_nx;
	logic [DATA_W-1:0]  rd_mux;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && rsp_free;
	assign req_stall = valid_s1 && !rsp_free;
	assign req_take  = req_valid && !req_stall;

	assign count_e = EW'(count_q);
	assign pos_e   = EW'(pos_s1);
	assign full    = (count_e >= CAP_E);
	assign empty   = (count_q == '0);
	assign pos_ok  = (pos_e < count_e);

	// pick the addressed cell; position reaches at most the first RD_N cells
	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (pos_s1 == POS_W'(i))
				rd_mux = cells_q[i];
		end
	end

	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		idx    = '0;
		cnt_nx = count_q;
		st_nx  = ST_DONE;
		rd_nx  = '0;
		case (op_s1)
			OP_INS_FRONT: begin
				if (full) begin
					st_nx = ST_FULL;
				end else begin
					do_ins = 1'b1;
					cnt_nx = count_q + CW'(1);
				end
			end
			OP_INS_REAR: begin
				if (full) begin
					st_nx = ST_FULL;
				end else begin
					do_ins = 1'b1;
					idx    = count_e;
					cnt_nx = count_q + CW'(1);
				end
			end
			OP_DEL_FRONT: begin
				if (empty) begin
					st_nx = ST_NOOP;
				end else begin
					do_del = 1'b1;
					cnt_nx = count_q - CW'(1);
				end
			end
			OP_DEL_REAR: begin
				// cells past the new count are dead; only the count drops
				if (empty) begin
					st_nx = ST_NOOP;
				end else begin
					cnt_nx = count_q - CW'(1);
				end
			end
			OP_INS_AT: begin
				if (!pos_ok) begin
					st_nx = ST_NOOP;
				end else if (full) begin
					st_nx = ST_FULL;
				end else begin
					do_ins = 1'b1;
					idx    = pos_e;
					cnt_nx = count_q + CW'(1);
				end
			end
			OP_DEL_AT: begin
				if (!pos_ok) begin
					st_nx = ST_NOOP;
				end else begin
					do_del = 1'b1;
					idx    = pos_e;
					cnt_nx = count_q - CW'(1);
				end
			end
			OP_READ: begin
				if (!pos_ok) begin
					st_nx = ST_NOOP;
				end else begin
					rd_nx = rd_mux;
				end
			end
			default: begin
				st_nx = ST_NOOP;
			end
		endcase
	end

	assign cnt_nx_e = EW'(cnt_nx);

	// insert: cells above idx take the left cell; delete: cells from idx take the right one
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam logic [EW-1:0] IDX_G = EW'(g);
		logic [DATA_W-1:0] left_v;
		logic [DATA_W-1:0] right_v;

		if (g == 0) begin : g_first
			assign left_v = cells_q[g];
		end else begin : g_left
			assign left_v = cells_q[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_v = cells_q[g];
		end else begin : g_right
			assign right_v = cells_q[g+1];
		end

		always_comb begin
			cells_nx[g] = cells_q[g];
			if (do_ins) begin
				if (IDX_G == idx)
					cells_nx[g] = val_s1;
				else if (IDX_G > idx)
					cells_nx[g] = left_v;
			end else if (do_del) begin
				if (IDX_G >= idx)
					cells_nx[g] = right_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < CAPACITY; i++)
				cells_q[i] <= cells_nx[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_take)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire)
				count_q <= cnt_nx;
			if (rsp_free)
				rsp_valid_q <= valid_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_s1  <= op_t'(op);
			pos_s1 <= position;
			val_s1 <= item_value;
		end
		if (fire) begin
			status_q      <= st_nx;
			read_value_q  <= rd_nx;
			entry_count_q <= cnt_nx_e[COUNT_OUT_W-1:0];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_e <= CAP_E)
		else $error("element count above capacity");

	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response held");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && st_nx == ST_FULL |=> count_q == $past(count_q))
		else $error("refused insert changed the count");

	a_full_only_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire && st_nx == ST_FULL |-> count_e == CAP_E)
		else $error("full status below capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");

endmodule
